/* sv/srd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg - subpicture RLE decoder shared types and constants
// Area registers, decoder state, per-nibble decode step and run record.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int SCREEN_WIDTH  = 720;
  localparam int SCREEN_HEIGHT = 576;
  localparam int NUM_COLORS    = 4;

  localparam logic [9:0] AREA_LEFT_RST   = 10'd0;
  localparam logic [9:0] AREA_TOP_RST    = 10'd0;
  localparam logic [9:0] AREA_RIGHT_RST  = 10'((SCREEN_WIDTH - 1) & 1023);
  localparam logic [9:0] AREA_BOTTOM_RST = 10'((SCREEN_HEIGHT - 1) & 1023);

  localparam logic [1:0] REG_AREA_LEFT   = 2'd0;
  localparam logic [1:0] REG_AREA_TOP    = 2'd1;
  localparam logic [1:0] REG_AREA_RIGHT  = 2'd2;
  localparam logic [1:0] REG_AREA_BOTTOM = 2'd3;

  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] right;
    logic [9:0] bottom;
  } area_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_field;
    logic       field_sel;
    logic       new_picture;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [9:0]                       x;
    logic [9:0]                       y;
    logic [11:0]                      acc;
    logic [1:0]                       held;
    logic                             fin;
    logic [NUM_COLORS-1:0][9:0]       min_x;
    logic [NUM_COLORS-1:0][9:0]       min_y;
    logic [NUM_COLORS-1:0][12:0]      max_x;
    logic [NUM_COLORS-1:0][9:0]       max_y;
  } dec_state_t;

  // Last member sits in the lowest bits: run_x at bit 0, field_done at bit 77.
  typedef struct packed {
    logic        field_done;
    logic [9:0]  box_bottom;
    logic [12:0] box_right;
    logic [9:0]  box_top;
    logic [9:0]  box_left;
    logic [1:0]  run_color;
    logic [11:0] run_len;
    logic [9:0]  run_y;
    logic [9:0]  run_x;
  } run_t;

  typedef struct packed {
    dec_state_t st;
    logic       emit;
    logic       wrap;
    run_t       run;
  } step_t;

  typedef struct packed {
    logic emit1;
    logic emit2;
    run_t run1;
    run_t run2;
  } dec_res_t;

  // Feed one nibble into the code assembler; update position and color box.
  function automatic step_t nib_step(dec_state_t s, logic [3:0] nib, area_t a);
    step_t       r;
    logic [15:0] code;
    logic        done;
    logic [1:0]  color;
    logic [11:0] len;
    logic [12:0] endx;
    logic [12:0] nx;
    logic [10:0] ny;
    r      = '0;
    r.st   = s;
    code   = {s.acc, nib};
    case (s.held)
      2'd0:    done = code >= 16'h0004;
      2'd1:    done = code >= 16'h0010;
      2'd2:    done = code >= 16'h0040;
      default: done = 1'b1;
    endcase
    color = code[1:0];
    // a completed code is always below 0x400, so its length fits here
    len   = code[13:2];
    if (len == 12'd0) begin
      len = (s.x <= a.right) ? 12'({2'b00, a.right} - {2'b00, s.x}) + 12'd1 : 12'd1;
    end
    endx = 13'(s.x) + 13'(len) - 13'd1;
    nx   = 13'(s.x) + 13'(len);
    ny   = 11'(s.y) + 11'd2;
    if (!done) begin
      r.st.acc  = code[11:0];
      r.st.held = s.held + 2'd1;
    end else begin
      r.st.acc  = '0;
      r.st.held = '0;
      r.emit    = 1'b1;
      if (s.min_x[color] > s.x) r.st.min_x[color] = s.x;
      if (s.min_y[color] > s.y) r.st.min_y[color] = s.y;
      if (s.max_x[color] < endx) r.st.max_x[color] = endx;
      if (s.max_y[color] < s.y) r.st.max_y[color] = s.y;
      r.run.run_x      = s.x;
      r.run.run_y      = s.y;
      r.run.run_len    = len;
      r.run.run_color  = color;
      r.run.box_left   = r.st.min_x[color];
      r.run.box_top    = r.st.min_y[color];
      r.run.box_right  = r.st.max_x[color];
      r.run.box_bottom = r.st.max_y[color];
      if (nx > 13'(a.right)) begin
        // line end: back to the left edge, skip to the next line of this field
        r.wrap   = 1'b1;
        r.st.x   = a.left;
        if (ny > 11'(a.bottom)) begin
          r.st.fin           = 1'b1;
          r.run.field_done   = 1'b1;
        end else begin
          r.st.y = ny[9:0];
        end
      end else begin
        r.st.x = nx[9:0];
      end
    end
    return r;
  endfunction

endpackage

/* sv/srd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_core - decoder state and two-nibble decode
// Holds position, partial code and color boxes; decodes one byte per fire.
// ----------------------------------------------------------------------------
module srd_core (
  input  logic               clk,
  input  logic               rst,
  input  srd_pkg::area_t     area,
  input  srd_pkg::item_t     item,
  input  logic               fire,
  output srd_pkg::dec_res_t  res
);
  import srd_pkg::*;

  dec_state_t st;
  dec_state_t st_next;
  dec_state_t s0;
  dec_state_t s1;
  dec_state_t s2;
  step_t      r1;
  step_t      r2;
  logic       en1;
  logic       en2;
  logic [10:0] y0;

  always_comb begin
    s0 = st;
    if (item.new_picture) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        s0.min_x[c] = area.right;
        s0.min_y[c] = area.bottom;
        s0.max_x[c] = 13'(area.left);
        s0.max_y[c] = area.top;
      end
    end
    y0 = 11'(area.top) + 11'(item.field_sel);
    if (item.start_field) begin
      s0.x    = area.left;
      s0.acc  = '0;
      s0.held = '0;
      if (y0 > 11'(area.bottom)) begin
        s0.y   = '0;
        s0.fin = 1'b1;
      end else begin
        s0.y   = y0[9:0];
        s0.fin = 1'b0;
      end
    end
    en1 = !s0.fin;
    r1  = nib_step(s0, item.data_byte[7:4], area);
    s1  = en1 ? r1.st : s0;
    // drop the low nibble once the high nibble ended the line
    en2 = en1 && !r1.wrap;
    r2  = nib_step(s1, item.data_byte[3:0], area);
    s2  = en2 ? r2.st : s1;
    st_next = s2;
    if (item.last_byte) begin
      st_next.acc  = '0;
      st_next.held = '0;
      st_next.fin  = 1'b1;
    end
    res.emit1 = en1 && r1.emit;
    res.emit2 = en2 && r2.emit;
    res.run1  = r1.run;
    res.run2  = r2.run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.x    <= '0;
      st.y    <= '0;
      st.acc  <= '0;
      st.held <= '0;
      st.fin  <= 1'b1;
      for (int c = 0; c < NUM_COLORS; c++) begin
        st.min_x[c] <= AREA_RIGHT_RST;
        st.min_y[c] <= AREA_BOTTOM_RST;
        st.max_x[c] <= 13'(AREA_LEFT_RST);
        st.max_y[c] <= AREA_TOP_RST;
      end
    end else if (fire) begin
      st <= st_next;
    end
  end

  a_fin_no_partial: assert property (@(posedge clk) disable iff (rst)
    st.fin |-> (st.held == 2'd0 && st.acc == 12'd0))
    else $error("finished field holds a partial code");

  a_idle_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (st.held == 2'd0) |-> (st.acc == 12'd0))
    else $error("code accumulator not clear with no nibbles held");

  a_three_held_short: assert property (@(posedge clk) disable iff (rst)
    (st.held == 2'd3) |-> (st.acc < 12'h040))
    else $error("three held nibbles should form an incomplete code");

endmodule

/* sv/subpicture_rle_decoder_unit.sv */
`timescale 1ns / 1ps
// Pipeline: an accepted byte is held in the input register, then decoded, and its first run
//   is registered into the output register once the output stage can take it.
// Throughput: one byte per cycle when it yields at most one run and m_tready is high;
//   a two-run byte parks its second run in the skid slot; the next byte waits until it drains.
// Reset (rst, synchronous): empties input and output stages, restores the full-screen
//   area, clears position and code state; the decoder idles until a start_field byte.
// ----------------------------------------------------------------------------
// subpicture_rle_decoder_unit - 2-bit subpicture RLE decoder
// Input register, single-pass byte decode, output register with one skid slot.
// ----------------------------------------------------------------------------
module subpicture_rle_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [2:0]  s_tuser,   // start_field, field_sel, new_picture
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [srd_pkg::OUT_DATA_W-1:0] m_tdata, // run_x, run_y, run_len, run_color,
                                 // box_left, box_top, box_right, box_bottom,
                                 // field_done, 2 zero bits
  output logic        m_tlast    // last
);
  import srd_pkg::*;

  area_t    area;
  item_t    in_item;
  logic     in_v;
  logic     proc;
  dec_res_t res;
  run_t     out_run;
  logic     out_v;
  logic     out_last;
  run_t     pend_run;
  logic     pend_v;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      area.left   <= AREA_LEFT_RST;
      area.top    <= AREA_TOP_RST;
      area.right  <= AREA_RIGHT_RST;
      area.bottom <= AREA_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_LEFT:   area.left <= cfg_data;
        REG_AREA_TOP:    area.top  <= cfg_data;
        REG_AREA_RIGHT:  area.right <= (int'(cfg_data) > SCREEN_WIDTH - 1) ?
                                       10'(SCREEN_WIDTH - 1) : cfg_data;
        REG_AREA_BOTTOM: area.bottom <= (int'(cfg_data) > SCREEN_HEIGHT - 1) ?
                                        10'(SCREEN_HEIGHT - 1) : cfg_data;
        default: ;
      endcase
    end
  end

  // decode only when both output slots can take the byte's runs
  assign proc     = in_v && !pend_v && (!out_v || m_tready);
  assign s_tready = !in_v || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte   <= s_tdata;
      in_item.start_field <= s_tuser[0];
      in_item.field_sel   <= s_tuser[1];
      in_item.new_picture <= s_tuser[2];
      in_item.last_byte   <= s_tlast;
    end
  end

  srd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .area (area),
    .item (in_item),
    .fire (proc),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      pend_v <= 1'b0;
    end else if (proc) begin
      if (res.emit1 && res.emit2) begin
        out_v    <= 1'b1;
        out_run  <= res.run1;
        out_last <= 1'b0;
        pend_v   <= 1'b1;
        pend_run <= res.run2;
      end else if (res.emit1) begin
        out_v    <= 1'b1;
        out_run  <= res.run1;
        out_last <= 1'b1;
      end else if (res.emit2) begin
        out_v    <= 1'b1;
        out_run  <= res.run2;
        out_last <= 1'b1;
      end else begin
        out_v <= out_v && !m_tready;
      end
    end else if (out_v && m_tready) begin
      // advance the held second run into the output register
      if (pend_v) begin
        out_run  <= pend_run;
        out_last <= 1'b1;
        pend_v   <= 1'b0;
      end else begin
        out_v <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {2'b00, out_run};
  assign m_tlast  = out_last;

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> out_v)
    else $error("skid slot full while output register empty");

  a_run_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (proc && (res.emit1 || res.emit2)) |=> out_v)
    else $error("decoded run not presented");

  a_pair_split: assert property (@(posedge clk) disable iff (rst)
    (proc && res.emit1 && res.emit2) |=> (pend_v && !out_last))
    else $error("second run of a byte lost or first run marked last");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - subpicture RLE decoder unit testbench
// Streams RLE bytes through the decoder under randomized idle and backpressure,
// predicts each decoded run with a behavioral decoder kept in step with the
// area registers, and compares every output run field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import srd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_PAUSE  = 8;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 110;

  // code-complete thresholds after one, two and three held nibbles
  localparam int unsigned CODE_DONE_1 = 'h0004;
  localparam int unsigned CODE_DONE_2 = 'h0010;
  localparam int unsigned CODE_DONE_3 = 'h0040;

  typedef struct {
    run_t run;
    bit   last;
  } expected_run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte
  logic [2:0]  s_tuser = '0;   // start_field, field_sel, new_picture
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // run_x, run_y, run_len, run_color, box_left, box_top,
                               // box_right, box_bottom, field_done, 2 zero bits
  logic        m_tlast;        // last

  subpicture_rle_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Decoder shadow: area window, position, code assembly and color boxes
  int unsigned win_left, win_top, win_right, win_bottom;
  int unsigned pos_x, pos_y, code_acc, nib_held;
  bit          field_idle;
  int unsigned bmin_x[NUM_COLORS], bmin_y[NUM_COLORS];
  int unsigned bmax_x[NUM_COLORS], bmax_y[NUM_COLORS];

  item_t         byte_queue[$];
  expected_run_t pending_runs[$];
  item_t         cur_item;
  int            mismatches = 0;
  int            items_queued = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  int            quiet_cycles = 0;
  bit            quiet = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void invert_boxes();
    for (int c = 0; c < NUM_COLORS; c++) begin
      bmin_x[c] = win_right;
      bmin_y[c] = win_bottom;
      bmax_x[c] = win_left;
      bmax_y[c] = win_top;
    end
  endfunction

  // Push one nibble into the code assembler; returns 1 when a run completes.
  function automatic bit feed_nibble(input int unsigned nib, output bit wrapped,
                                     output run_t run);
    int unsigned code, len, end_x, next_x, c;
    bit          complete;
    wrapped = 1'b0;
    run     = '0;
    code    = ((code_acc << 4) | nib) & 'hFFFF;
    case (nib_held)
      0:       complete = code >= CODE_DONE_1;
      1:       complete = code >= CODE_DONE_2;
      2:       complete = code >= CODE_DONE_3;
      default: complete = 1'b1;
    endcase
    if (!complete) begin
      code_acc = code;
      nib_held = nib_held + 1;
      return 1'b0;
    end
    code_acc = 0;
    nib_held = 0;
    c   = code & 3;
    len = code >> 2;
    // zero length fills to the right edge, or one pixel when already past it
    if (len == 0) len = (pos_x <= win_right) ? win_right - pos_x + 1 : 1;
    end_x = pos_x + len - 1;
    if (bmin_x[c] > pos_x) bmin_x[c] = pos_x;
    if (bmin_y[c] > pos_y) bmin_y[c] = pos_y;
    if (bmax_x[c] < end_x) bmax_x[c] = end_x;
    if (bmax_y[c] < pos_y) bmax_y[c] = pos_y;
    run.run_x      = 10'(pos_x);
    run.run_y      = 10'(pos_y);
    run.run_len    = 12'(len);
    run.run_color  = 2'(c);
    run.box_left   = 10'(bmin_x[c]);
    run.box_top    = 10'(bmin_y[c]);
    run.box_right  = 13'(bmax_x[c]);
    run.box_bottom = 10'(bmax_y[c]);
    next_x = pos_x + len;
    if (next_x > win_right) begin
      wrapped = 1'b1;
      pos_x   = win_left;
      if (pos_y + 2 > win_bottom) begin
        field_idle     = 1'b1;
        run.field_done = 1'b1;
      end else begin
        pos_y = pos_y + 2;
      end
    end else begin
      pos_x = next_x;
    end
    return 1'b1;
  endfunction

  function automatic void decode_byte(input item_t it);
    run_t        runs[2];
    run_t        r;
    int          n;
    bit          wrapped;
    int unsigned nib;
    n = 0;
    if (it.new_picture) invert_boxes();
    if (it.start_field) begin
      pos_x    = win_left;
      code_acc = 0;
      nib_held = 0;
      if (win_top + it.field_sel > win_bottom) begin
        pos_y      = 0;
        field_idle = 1'b1;
      end else begin
        pos_y      = win_top + it.field_sel;
        field_idle = 1'b0;
      end
    end
    for (int k = 0; k < 2 && !field_idle; k++) begin
      nib = k ? it.data_byte[3:0] : it.data_byte[7:4];
      if (feed_nibble(nib, wrapped, r)) begin
        runs[n] = r;
        n++;
      end
      if (wrapped) break;
    end
    // drop any partial code at the end of field data
    if (it.last_byte) begin
      code_acc   = 0;
      nib_held   = 0;
      field_idle = 1'b1;
    end
    for (int k = 0; k < n; k++) pending_runs.push_back('{runs[k], k == n - 1});
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_AREA_LEFT:   win_left = val;
      REG_AREA_TOP:    win_top = val;
      REG_AREA_RIGHT:  win_right = (val > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : val;
      REG_AREA_BOTTOM: win_bottom = (val > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : val;
      default: ;
    endcase
  endtask

  task automatic program_area(input logic [9:0] l, t, r, b);
    write_reg(REG_AREA_LEFT, l);
    write_reg(REG_AREA_TOP, t);
    write_reg(REG_AREA_RIGHT, r);
    write_reg(REG_AREA_BOTTOM, b);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input logic [7:0] d, input bit start, fsel, newp, lastb);
    byte_queue.push_back('{data_byte: d, start_field: start, field_sel: fsel,
                           new_picture: newp, last_byte: lastb});
    items_queued++;
  endtask

  // Well-formed field: a run of random codes, byte-aligned after fills.
  task automatic add_field(input int n_codes);
    int unsigned nibs[$];
    int unsigned code;
    int          kind, width, nbytes;
    bit          with_start, ends;
    with_start = $urandom_range(0, 9) != 0;
    ends       = $urandom_range(0, 99) < 85;
    for (int i = 0; i < n_codes; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        code = $urandom_range('h4, 'hF);
        width = 1;
      end else if (kind < 52) begin
        code = $urandom_range('h10, 'h3F);
        width = 2;
      end else if (kind < 70) begin
        code = $urandom_range('h40, 'hFF);
        width = 3;
      end else if (kind < 82) begin
        code = $urandom_range('h100, 'h3FF);
        width = 4;
      end else begin
        code = $urandom_range(0, 3);
        width = 4;
      end
      for (int j = width - 1; j >= 0; j--) nibs.push_back((code >> (4 * j)) & 'hF);
      // a fill always ends the line, so pad to the byte boundary
      if (code < 4 && nibs.size() % 2 == 1) nibs.push_back($urandom_range(0, 15));
    end
    if (nibs.size() % 2 == 1) nibs.push_back($urandom_range(0, 15));
    nbytes = nibs.size() / 2;
    for (int i = 0; i < nbytes; i++) begin
      add_item({4'(nibs[2 * i]), 4'(nibs[2 * i + 1])},
               with_start && i == 0,
               1'($urandom_range(0, 1)),
               (i == 0) ? ($urandom_range(0, 99) < 30) : ($urandom_range(0, 99) < 3),
               ends && i == nbytes - 1);
    end
  endtask

  // Wait until every byte is taken and every run returned, then let the pipe settle.
  task automatic drain();
    while (byte_queue.size() != 0 || s_tvalid || pending_runs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        decode_byte(cur_item);
        send_gap = quiet ? 0 : pick_gap();
      end
      if (send_gap != 0 || byte_queue.size() == 0) begin
        if (send_gap != 0) send_gap--;
        s_tvalid <= 1'b0;
      end else begin
        cur_item = byte_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_item.data_byte;
        s_tuser  <= {cur_item.new_picture, cur_item.field_sel, cur_item.start_field};
        s_tlast  <= cur_item.last_byte;
      end
    end
  end

  // Run monitor and backpressure
  always @(posedge clk) begin
    expected_run_t want;
    run_t          got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[77:0];
      if (pending_runs.size() == 0) begin
        $error("unexpected run: x %0d y %0d len %0d color %0d",
               got.run_x, got.run_y, got.run_len, got.run_color);
        mismatches++;
      end else begin
        want = pending_runs.pop_front();
        check_field("run_x", want.run.run_x, got.run_x);
        check_field("run_y", want.run.run_y, got.run_y);
        check_field("run_len", want.run.run_len, got.run_len);
        check_field("run_color", want.run.run_color, got.run_color);
        check_field("box_left", want.run.box_left, got.box_left);
        check_field("box_top", want.run.box_top, got.box_top);
        check_field("box_right", want.run.box_right, got.box_right);
        check_field("box_bottom", want.run.box_bottom, got.box_bottom);
        check_field("field_done", want.run.field_done, got.field_done);
        check_field("tdata_pad", 0, m_tdata[79:78]);
        check_field("last", want.last, m_tlast);
      end
    end
    if (recv_gap != 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      recv_gap = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [9:0] l, t, r, b;
    int         w, h, sel, phase_end;

    win_left   = AREA_LEFT_RST;
    win_top    = AREA_TOP_RST;
    win_right  = AREA_RIGHT_RST;
    win_bottom = AREA_BOTTOM_RST;
    pos_x      = 0;
    pos_y      = 0;
    code_acc   = 0;
    nib_held   = 0;
    field_idle = 1'b1;
    invert_boxes();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full screen after reset: idle byte, every code width, fill, two-run byte,
    // discarded partial code, ignored byte after end of data.
    add_item(8'hFF, 0, 0, 1, 0);
    add_item(8'h00, 1, 0, 1, 0);
    add_item(8'h00, 0, 0, 0, 0);
    add_item(8'h4F, 0, 0, 0, 0);
    add_item(8'h13, 0, 0, 0, 0);
    add_item(8'h04, 0, 0, 0, 0);
    add_item(8'h0E, 0, 0, 0, 0);
    add_item(8'h03, 0, 0, 0, 0);
    add_item(8'hFF, 0, 0, 0, 0);
    add_item(8'h00, 0, 0, 0, 1);
    add_item(8'h5A, 0, 0, 0, 0);
    add_item(8'hFF, 1, 1, 0, 1);
    drain();

    // Bottom-right corner, out-of-range writes clip to the screen
    program_area(10'd700, 10'd570, 10'd1023, 10'd1023);
    add_item(8'h00, 1, 0, 1, 0);
    add_item(8'h01, 0, 0, 0, 0);
    add_item(8'h00, 0, 0, 0, 0);
    add_item(8'h02, 0, 0, 0, 0);
    add_item(8'h00, 0, 0, 0, 0);
    add_item(8'h03, 0, 0, 0, 0);
    add_item(8'h77, 0, 0, 0, 0);
    add_item(8'h00, 1, 1, 0, 0);
    add_item(8'h00, 0, 0, 0, 0);
    add_item(8'hFF, 0, 0, 0, 1);
    drain();

    // Start line below the area: field ends at once
    program_area(10'd719, 10'd575, 10'd0, 10'd574);
    add_item(8'hC0, 1, 0, 1, 0);
    drain();

    // Left edge beyond right edge: a fill gives a single pixel
    program_area(10'd719, 10'd575, 10'd0, 10'd575);
    add_item(8'h00, 1, 0, 1, 0);
    add_item(8'h02, 0, 0, 0, 1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sel = $urandom_range(0, 9);
      l = 10'($urandom_range(0, 719));
      t = 10'($urandom_range(0, 575));
      if (sel < 6) begin
        w = $urandom_range(1, 40);
        h = $urandom_range(0, 12);
      end else begin
        w = $urandom_range(1, 300);
        h = $urandom_range(0, 40);
      end
      r = 10'(l + w - 1);
      b = 10'(t + h);
      if (sel == 8) begin
        l = 10'($urandom_range(0, 1023));
        t = 10'($urandom_range(0, 1023));
        r = 10'($urandom_range(0, 1023));
        b = 10'($urandom_range(0, 1023));
      end else if (sel == 9) begin
        l = 10'($urandom_range(0, 16));
        t = 10'($urandom_range(0, 8));
        r = 10'($urandom_range(700, 1023));
        b = 10'($urandom_range(560, 1023));
      end
      program_area(l, t, r, b);
      quiet = $urandom_range(0, 3) == 0;
      phase_end = items_queued + PHASE_ITEMS;
      while (items_queued < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          add_field($urandom_range(1, 24));
        end else begin
          add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
